/* sv/assert_macros.svh */
// Assertion macros for the RTL of the range-minimum segment tree unit.
// No dependencies; compiled away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check under reset disable.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check at every edge.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* sv/rmst_pkg.sv */
// Widths, constants and types of the range-minimum segment tree.
// No dependencies.
`default_nettype none
package rmst_pkg;
  localparam int LEAF_W  = 10;
  localparam int LEAVES  = 1 << LEAF_W;
  localparam int NODE_W  = LEAF_W + 1;
  localparam int BOUND_W = LEAF_W + 2;
  localparam int VAL_W   = 30;
  localparam int OFF_W   = 11;
  localparam int IDX_W   = 11;
  localparam int RANGE_W = 12;
  localparam int POS_W   = (LEAF_W + 3 > 13) ? LEAF_W + 3 : 13;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [VAL_W-1:0] EMPTY_MARK = 30'h3f3f3f3f;

  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  localparam logic REG_INDEX_OFFSET = 1'b0;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic [NODE_W-1:0] raddr;
  } ram_req_t;
endpackage
`default_nettype wire

/* sv/rmst_node_ram.sv */
// Node memory of the segment tree: one write and one read port, registered read.
// Depends on rmst_pkg.
`default_nettype none
module rmst_node_ram (
  input  wire logic                      clk,
  input  wire rmst_pkg::ram_req_t        req,
  output logic [rmst_pkg::VAL_W-1:0]     rdata
);
  logic [rmst_pkg::VAL_W-1:0] mem [2*rmst_pkg::LEAVES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule
`default_nettype wire

/* sv/range_min_segment_tree_unit.sv */
// Channel   | Handshake            | Payload
// request   | start / busy         | in_func, in_leaf_index, in_new_value, in_range_*
// result    | out_valid (1 cycle)  | out_min_value
// config    | APB psel/penable     | index_offset at byte address 0
// An update does one node memory read and one write per level, from the leaf up to the root.
// A query walks up the tree level by level, reading the low-bound node in S_QL and the
// high-bound node in S_QR, bound by the single read port of the node memory.
// After reset a clearing pass writes all 2*LEAVES node memory entries with the
// empty marker; busy stays high through it. Config writes are taken at any time.
// Results cannot be stalled; out_valid is high for exactly one cycle.
// Depends on rmst_pkg, rmst_node_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module range_min_segment_tree_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_func,
  input  wire logic signed [rmst_pkg::IDX_W-1:0]  in_leaf_index,
  input  wire logic [rmst_pkg::VAL_W-1:0]         in_new_value,
  input  wire logic signed [rmst_pkg::RANGE_W-1:0] in_range_low,
  input  wire logic signed [rmst_pkg::RANGE_W-1:0] in_range_high,
  output logic                                    out_valid,
  output logic [rmst_pkg::VAL_W-1:0]              out_min_value,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [rmst_pkg::CFG_AW-1:0]        paddr,
  input  wire logic [rmst_pkg::CFG_DW-1:0]        pwdata,
  output logic [rmst_pkg::CFG_DW-1:0]             prdata,
  output logic                                    pready
);
  localparam int NW = rmst_pkg::NODE_W;
  localparam int BW = rmst_pkg::BOUND_W;
  localparam int VW = rmst_pkg::VAL_W;
  localparam int PW = rmst_pkg::POS_W;
  localparam int DW = rmst_pkg::CFG_DW;

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_UPD, S_QL, S_QR} state_t;

  state_t                    state_r, state_nxt;
  logic [NW-1:0]             clr_cnt_r, clr_cnt_nxt;
  logic [NW-1:0]             node_r, node_nxt;
  logic [VW-1:0]             cur_r, cur_nxt;
  logic [BW-1:0]             l_r, l_nxt, r_r, r_nxt;
  logic [VW-1:0]             res_r, res_nxt;
  logic                      pend_r, pend_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [VW-1:0]             out_min_value_r, out_min_value_nxt;
  logic [rmst_pkg::OFF_W-1:0] offset_r, offset_nxt;

  rmst_pkg::ram_req_t        ram_req;
  logic [VW-1:0]             rdata;

  logic signed [PW-1:0]      upd_pos, lo_pos, hi_pos;
  logic                      upd_ok;
  logic [NW-1:0]             leaf_node, parent;
  logic [VW-1:0]             par_val, res_eff;
  logic [BW-1:0]             r_dec;
  logic                      cfg_wr;

  function automatic logic [BW-1:0] clamp_node(input logic signed [PW-1:0] v);
    logic [BW-1:0] n;
    if (v < 0) begin
      n = BW'(rmst_pkg::LEAVES);
    end else if (v > PW'(rmst_pkg::LEAVES)) begin
      n = BW'(2 * rmst_pkg::LEAVES);
    end else begin
      n = BW'(rmst_pkg::LEAVES) + BW'(v[rmst_pkg::LEAF_W:0]);
    end
    return n;
  endfunction

  rmst_node_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  assign upd_pos = {{(PW - rmst_pkg::IDX_W){in_leaf_index[rmst_pkg::IDX_W-1]}}, in_leaf_index}
                 + PW'(offset_r);
  assign lo_pos  = {{(PW - rmst_pkg::RANGE_W){in_range_low[rmst_pkg::RANGE_W-1]}},
                    in_range_low} + PW'(offset_r);
  assign hi_pos  = {{(PW - rmst_pkg::RANGE_W){in_range_high[rmst_pkg::RANGE_W-1]}},
                    in_range_high} + PW'(offset_r);
  assign upd_ok    = (upd_pos >= 0) && (upd_pos < PW'(rmst_pkg::LEAVES));
  assign leaf_node = {1'b1, upd_pos[rmst_pkg::LEAF_W-1:0]};
  assign parent    = {1'b0, node_r[NW-1:1]};
  assign par_val   = (rdata < cur_r) ? rdata : cur_r;
  assign res_eff   = (pend_r && (rdata < res_r)) ? rdata : res_r;
  assign r_dec     = r_r[0] ? (r_r - BW'(1)) : r_r;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == rmst_pkg::REG_INDEX_OFFSET) ? DW'(offset_r) : '0;

  always_comb begin
    offset_nxt = offset_r;
    if (cfg_wr && (paddr[2] == rmst_pkg::REG_INDEX_OFFSET)) begin
      offset_nxt = pwdata[rmst_pkg::OFF_W-1:0];
    end
  end

  always_comb begin
    state_nxt         = state_r;
    clr_cnt_nxt       = clr_cnt_r;
    node_nxt          = node_r;
    cur_nxt           = cur_r;
    l_nxt             = l_r;
    r_nxt             = r_r;
    res_nxt           = res_r;
    pend_nxt          = 1'b0;
    out_valid_nxt     = 1'b0;
    out_min_value_nxt = out_min_value_r;
    ram_req.we        = 1'b0;
    ram_req.waddr     = node_r;
    ram_req.wdata     = cur_r;
    ram_req.raddr     = node_r ^ NW'(1);
    unique case (state_r)
      S_CLR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_cnt_r;
        ram_req.wdata = rmst_pkg::EMPTY_MARK;
        clr_cnt_nxt   = clr_cnt_r + NW'(1);
        if (clr_cnt_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (in_func == rmst_pkg::FUNC_QUERY) begin
            l_nxt     = clamp_node(lo_pos);
            r_nxt     = clamp_node(hi_pos);
            res_nxt   = rmst_pkg::EMPTY_MARK;
            state_nxt = S_QL;
          end else if (upd_ok) begin
            // write the leaf and fetch its sibling in the same cycle
            ram_req.we    = 1'b1;
            ram_req.waddr = leaf_node;
            ram_req.wdata = in_new_value;
            ram_req.raddr = leaf_node ^ NW'(1);
            node_nxt      = leaf_node;
            cur_nxt       = in_new_value;
            state_nxt     = S_UPD;
          end
        end
      end
      S_UPD: begin
        // rdata holds the sibling; write the parent, fetch the parent's sibling
        ram_req.we    = 1'b1;
        ram_req.waddr = parent;
        ram_req.wdata = par_val;
        ram_req.raddr = parent ^ NW'(1);
        node_nxt      = parent;
        cur_nxt       = par_val;
        if (parent == NW'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_QL: begin
        res_nxt = res_eff;
        if (l_r < r_r) begin
          if (l_r[0]) begin
            ram_req.raddr = l_r[NW-1:0];
            l_nxt         = l_r + BW'(1);
            pend_nxt      = 1'b1;
          end
          state_nxt = S_QR;
        end else begin
          out_valid_nxt     = 1'b1;
          out_min_value_nxt = res_eff;
          state_nxt         = S_IDLE;
        end
      end
      S_QR: begin
        res_nxt = res_eff;
        if (r_r[0]) begin
          ram_req.raddr = r_dec[NW-1:0];
          pend_nxt      = 1'b1;
        end
        // advance both bounds one level up
        l_nxt     = l_r >> 1;
        r_nxt     = r_dec >> 1;
        state_nxt = S_QL;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      offset_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      offset_r    <= offset_nxt;
    end
    node_r          <= node_nxt;
    cur_r           <= cur_nxt;
    l_r             <= l_nxt;
    r_r             <= r_nxt;
    res_r           <= res_nxt;
    out_min_value_r <= out_min_value_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_min_value = out_min_value_r;

  `ASSERT_RST(a_result_single, clk, rst_n, out_valid_r |=> !out_valid_r, "result strobe repeated")
  `ASSERT_RST(a_result_idle, clk, rst_n, out_valid_r |-> (state_r == S_IDLE), "result while busy")
  `ASSERT_RST(a_upd_below_root, clk, rst_n, (state_r == S_UPD) |-> (node_r > NW'(1)), "update walked past root")
  `ASSERT_RST(a_query_no_write, clk, rst_n, ((state_r == S_QL) || (state_r == S_QR)) |-> !ram_req.we, "write during query")
endmodule
`default_nettype wire

/* tb/sv/tb_range_min_segment_tree_unit.sv */
// Self-checking testbench for range_min_segment_tree_unit: point updates and
// range-minimum queries checked against a segment tree kept in the testbench.
// Depends on rmst_pkg and the RTL of the block; reads no files.
`default_nettype none
module tb_range_min_segment_tree_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEAVES  = rmst_pkg::LEAVES;
  localparam int IDX_W   = rmst_pkg::IDX_W;
  localparam int VAL_W   = rmst_pkg::VAL_W;
  localparam int RANGE_W = rmst_pkg::RANGE_W;
  localparam int OFF_W   = rmst_pkg::OFF_W;
  localparam int CFG_AW  = rmst_pkg::CFG_AW;
  localparam int CFG_DW  = rmst_pkg::CFG_DW;

  localparam int WATCHDOG_LIMIT = 8000;
  localparam int PHASE_ITEMS    = 100;

  localparam logic [CFG_AW-1:0] OFFSET_ADDR = {rmst_pkg::REG_INDEX_OFFSET, 2'b00};
  // register index 1 is not implemented; writes to it must leave the offset alone
  localparam logic [CFG_AW-1:0] SPARE_ADDR  = 3'b100;

  typedef struct {
    logic                      func;
    logic signed [IDX_W-1:0]   leaf_index;
    logic [VAL_W-1:0]          new_value;
    logic signed [RANGE_W-1:0] range_low;
    logic signed [RANGE_W-1:0] range_high;
  } tree_request_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start = 1'b0;
  logic busy;
  logic in_func = rmst_pkg::FUNC_UPDATE;
  logic signed [IDX_W-1:0] in_leaf_index = '0;
  logic [VAL_W-1:0] in_new_value = '0;
  logic signed [RANGE_W-1:0] in_range_low = '0;
  logic signed [RANGE_W-1:0] in_range_high = '0;
  logic out_valid;
  logic [VAL_W-1:0] out_min_value;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  tree_request_t request_q[$];
  logic [VAL_W-1:0] expected_min_q[$];
  logic [VAL_W-1:0] tree_min [2*LEAVES];
  logic [OFF_W-1:0] cur_offset;
  tree_request_t drive_req;
  logic req_taken = 1'b0;
  logic cfg_written = 1'b0;
  logic gaps_on;
  int gap_left = 0;
  int stall_cycles = 0;
  int error_count = 0;

  range_min_segment_tree_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_leaf_index(in_leaf_index),
    .in_new_value (in_new_value),
    .in_range_low (in_range_low),
    .in_range_high(in_range_high),
    .out_valid    (out_valid),
    .out_min_value(out_min_value),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic add_request(input tree_request_t r);
    request_q = {request_q, r};
  endtask

  task automatic store_leaf(input logic signed [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
    int p;
    int node;
    p = int'(idx) + int'(cur_offset);
    if (p >= 0 && p < LEAVES) begin
      node = p + LEAVES;
      tree_min[node] = val;
      while (node > 1) begin
        tree_min[node >> 1] = (tree_min[node] < tree_min[node ^ 1]) ?
                              tree_min[node] : tree_min[node ^ 1];
        node = node >> 1;
      end
    end
  endtask

  function automatic int clamp_leaf(input logic signed [RANGE_W-1:0] bound);
    int v;
    v = int'(bound) + int'(cur_offset);
    if (v < 0) return 0;
    if (v > LEAVES) return LEAVES;
    return v;
  endfunction

  function automatic logic [VAL_W-1:0] query_min(input logic signed [RANGE_W-1:0] lo_b,
                                                  input logic signed [RANGE_W-1:0] hi_b);
    logic [VAL_W-1:0] best;
    int l;
    int r;
    best = rmst_pkg::EMPTY_MARK;
    l = clamp_leaf(lo_b) + LEAVES;
    r = clamp_leaf(hi_b) + LEAVES;
    while (l < r) begin
      if (l % 2 == 1) begin
        if (tree_min[l] < best) best = tree_min[l];
        l++;
      end
      if (r % 2 == 1) begin
        r--;
        if (tree_min[r] < best) best = tree_min[r];
      end
      l = l >> 1;
      r = r >> 1;
    end
    return best;
  endfunction

  function automatic tree_request_t make_req(input logic func,
                                             input logic signed [IDX_W-1:0] idx,
                                             input logic [VAL_W-1:0] val,
                                             input logic signed [RANGE_W-1:0] lo_b,
                                             input logic signed [RANGE_W-1:0] hi_b);
    tree_request_t r;
    r.func       = func;
    r.leaf_index = idx;
    r.new_value  = val;
    r.range_low  = lo_b;
    r.range_high = hi_b;
    return r;
  endfunction

  // Mostly in-tree indexes and in-tree ranges, the ranges mostly short; the rest is raw noise.
  function automatic tree_request_t random_request(input logic [OFF_W-1:0] off);
    tree_request_t r;
    int p;
    int lo_leaf;
    int hi_leaf;
    r.func       = ($urandom_range(0, 99) < 55) ? rmst_pkg::FUNC_QUERY : rmst_pkg::FUNC_UPDATE;
    r.leaf_index = IDX_W'($urandom);
    r.new_value  = VAL_W'($urandom);
    r.range_low  = RANGE_W'($urandom);
    r.range_high = RANGE_W'($urandom);
    if ($urandom_range(0, 9) < 8) begin
      p = $urandom_range(0, LEAVES - 1) - int'(off);
      if (p >= -1024 && p <= 1023) r.leaf_index = IDX_W'(p);
      if ($urandom_range(0, 3) != 0) r.new_value = VAL_W'($urandom_range(0, 100000));
      lo_leaf = $urandom_range(0, LEAVES);
      hi_leaf = lo_leaf + (($urandom_range(0, 3) == 0) ? $urandom_range(0, LEAVES)
                                                        : $urandom_range(0, 40));
      if (hi_leaf > LEAVES) hi_leaf = LEAVES;
      if ($urandom_range(0, 15) == 0) hi_leaf = lo_leaf - $urandom_range(0, 5);
      r.range_low  = RANGE_W'(lo_leaf - int'(off));
      r.range_high = RANGE_W'(hi_leaf - int'(off));
    end
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!cfg_written);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain_requests;
    while (request_q.size() != 0 || start) @(negedge clk);
    // the driver may launch the last request on this very edge
    @(negedge clk);
    while (start || busy || expected_min_q.size() != 0) @(negedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !req_taken) begin
      // hold the request until the block takes it
    end else if (gap_left != 0) begin
      start    <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (gaps_on && request_q.size() != 0 && $urandom_range(0, 7) == 0) begin
      start    <= 1'b0;
      gap_left <= $urandom_range(0, 5);
    end else if (request_q.size() != 0) begin
      drive_req = request_q[0];
      request_q.delete(0);
      start         <= 1'b1;
      in_func       <= drive_req.func;
      in_leaf_index <= drive_req.leaf_index;
      in_new_value  <= drive_req.new_value;
      in_range_low  <= drive_req.range_low;
      in_range_high <= drive_req.range_high;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    int k;
    req_taken   <= rst_n && start && !busy;
    cfg_written <= rst_n && psel && penable && pwrite && pready;
    if (!rst_n) begin
      cur_offset = '0;
      for (k = 0; k < 2 * LEAVES; k++) tree_min[k] = rmst_pkg::EMPTY_MARK;
    end
    if (rst_n && psel && penable && pwrite && pready &&
        paddr[2] == rmst_pkg::REG_INDEX_OFFSET)
      cur_offset = pwdata[OFF_W-1:0];
    if (rst_n && start && !busy) begin
      if (in_func == rmst_pkg::FUNC_UPDATE)
        store_leaf(in_leaf_index, in_new_value);
      else
        expected_min_q = {expected_min_q, query_min(in_range_low, in_range_high)};
    end
    if (rst_n && out_valid) begin
      if (expected_min_q.size() == 0) begin
        $error("out_min_value: expected none, actual %h", out_min_value);
        error_count++;
      end else if (expected_min_q[0] !== out_min_value) begin
        $error("out_min_value: expected %h, actual %h", expected_min_q[0], out_min_value);
        error_count++;
        expected_min_q.delete(0);
      end else begin
        expected_min_q.delete(0);
      end
    end
    if ((start && !busy) || out_valid || (psel && penable && pwrite && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int k;
    int ph;
    logic [OFF_W-1:0] off;
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    gaps_on       = 1'b1;

    // offset at its reset value; queued now, taken once the clearing pass ends
    add_request(make_req(rmst_pkg::FUNC_QUERY, 0, 0, -1024, 1024));
    add_request(make_req(rmst_pkg::FUNC_UPDATE, 0, 5, 0, 0));
    add_request(make_req(rmst_pkg::FUNC_UPDATE, 1023, 0, 0, 0));
    add_request(make_req(rmst_pkg::FUNC_UPDATE, -1, 1, 0, 0));
    add_request(make_req(rmst_pkg::FUNC_UPDATE, -1024, 2, 0, 0));
    add_request(make_req(rmst_pkg::FUNC_UPDATE, 7, 30'h3fffffff, 0, 0));
    add_request(make_req(rmst_pkg::FUNC_UPDATE, 8, rmst_pkg::EMPTY_MARK, 0, 0));
    add_request(make_req(rmst_pkg::FUNC_UPDATE, 9, 123, 2047, -2048));
    add_request(make_req(rmst_pkg::FUNC_QUERY, 0, 0, 0, 1024));
    add_request(make_req(rmst_pkg::FUNC_QUERY, 0, 0, -2048, 2047));
    add_request(make_req(rmst_pkg::FUNC_QUERY, 0, 0, 7, 8));
    add_request(make_req(rmst_pkg::FUNC_QUERY, 0, 0, 7, 10));
    add_request(make_req(rmst_pkg::FUNC_QUERY, 0, 0, 10, 3));
    add_request(make_req(rmst_pkg::FUNC_QUERY, 0, 0, 5, 5));
    add_request(make_req(rmst_pkg::FUNC_QUERY, 0, 0, 1023, 1024));
    add_request(make_req(rmst_pkg::FUNC_QUERY, -1024, 30'h3fffffff, 0, 1));
    add_request(make_req(rmst_pkg::FUNC_QUERY, 0, 0, -1024, -1));
    add_request(make_req(rmst_pkg::FUNC_UPDATE, 1023, 30'h3fffffff, 0, 0));
    add_request(make_req(rmst_pkg::FUNC_QUERY, 0, 0, 1000, 1024));
    add_request(make_req(rmst_pkg::FUNC_QUERY, 0, 0, 0, 1023));
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    drain_requests();

    write_reg(OFFSET_ADDR, 32'(1024));
    write_reg(SPARE_ADDR, 32'h0000_0155);
    add_request(make_req(rmst_pkg::FUNC_UPDATE, -1024, 77, 0, 0));
    add_request(make_req(rmst_pkg::FUNC_UPDATE, 0, 1, 0, 0));
    add_request(make_req(rmst_pkg::FUNC_UPDATE, 1023, 1, 0, 0));
    add_request(make_req(rmst_pkg::FUNC_QUERY, 0, 0, -1024, 0));
    add_request(make_req(rmst_pkg::FUNC_QUERY, 0, 0, 0, 1024));
    drain_requests();

    write_reg(OFFSET_ADDR, 32'(2047));
    add_request(make_req(rmst_pkg::FUNC_UPDATE, -1024, 3, 0, 0));
    add_request(make_req(rmst_pkg::FUNC_QUERY, 0, 0, -1024, -1023));
    add_request(make_req(rmst_pkg::FUNC_QUERY, 0, 0, -2048, -2047));
    drain_requests();

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       off = '0;
        1:       off = OFF_W'(1024);
        2:       off = OFF_W'($urandom_range(1, 1023));
        3:       off = OFF_W'(512);
        default: off = OFF_W'($urandom_range(0, 1024));
      endcase
      write_reg(OFFSET_ADDR, {21'($urandom), off});
      // run the last phase back to back
      if (ph == 4) gaps_on = 1'b0;
      for (k = 0; k < PHASE_ITEMS; k++) add_request(random_request(off));
      drain_requests();
    end

    if (error_count == 0 && expected_min_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
+incdir+sv
sv/rmst_pkg.sv
sv/rmst_node_ram.sv
sv/range_min_segment_tree_unit.sv
tb/sv/tb_range_min_segment_tree_unit.sv
